// ===== rtl/isar_pkg.sv =====
// ----------------------------------------------------------------------------
// isar_pkg
// Shared types and codes for the interval set block: request and status
// codes, datapath commands and the datapath status bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isar_pkg;

  // Request codes.
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_BAD    = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Width of one span bound.
  localparam int unsigned BW = 32;

  // Commands from the controller to the datapath.
  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_CALC,
    CMD_SHIFT,
    CMD_FILL,
    CMD_FINISH
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;
    logic scan_done;
    logic skip;
    logic shift_done;
    logic fill_done;
  } dp_stat_t;

endpackage

// ===== rtl/isar_ram.sv =====
// ----------------------------------------------------------------------------
// isar_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isar_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/isar_dp.sv =====
// ----------------------------------------------------------------------------
// isar_dp
// Datapath of the interval set: request registers, the table memory, the
// scan accumulators, the splice calculation, the shift and fill engine and
// the result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isar_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  isar_pkg::cmd_t             cmd,
  output isar_pkg::dp_stat_t         stat,
  input  logic [1:0]                 in_req_type,
  input  logic signed [31:0]         in_span_start,
  input  logic signed [31:0]         in_span_end,
  output logic                       out_covered,
  output logic [1:0]                 out_status,
  output logic [6:0]                 out_interval_count
);

  localparam int unsigned AW = $clog2(CAPACITY > 1 ? CAPACITY : 2);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = 2 * isar_pkg::BW;

  // Request registers.
  logic [1:0]        req_r;
  logic signed [31:0] s_r, e_r;
  logic [CW-1:0]     count_r;

  // Scan state.
  logic [CW-1:0]     ptr_r;
  logic              rd_v_r;
  logic [CW-1:0]     ci_r, cj_r;
  logic              got_i_r;
  logic signed [31:0] sti_r, ej1_r;

  // Splice plan.
  logic [CW-1:0]     lo_r, dist_r, rem_r, src_r, mv_dst_r;
  logic [1:0]        n_r, fk_r;
  logic signed [31:0] ns0_r, ne0_r, ns1_r, ne1_r;
  logic [CW:0]       total_r;
  logic              full_r, down_r, mv_v_r;

  // Memory ports.
  logic              we;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DW-1:0]     wr_data, rd_data;
  logic signed [31:0] rs, re;

  // Plan values.
  logic              hit, lt_s, gt_e;
  logic [CW-1:0]     c_jj;
  logic [1:0]        c_n;
  logic signed [31:0] c_ns0, c_ne0;
  logic [CW:0]       c_base, c_total;
  logic              c_down;
  logic [CW:0]       c_dist;
  logic              icond, jcond;
  logic [CW+6:0]     cnt_ext;
  logic [CW+7:0]     tot_ext;

  isar_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rs = $signed(rd_data[DW-1:isar_pkg::BW]);
  assign re = $signed(rd_data[isar_pkg::BW-1:0]);

  // Per-entry conditions while scanning the sorted table.
  always_comb begin
    icond = 1'b0;
    jcond = 1'b0;
    unique case (req_r)
      isar_pkg::REQ_ADD: begin
        icond = re < s_r;
        jcond = rs <= e_r;
      end
      isar_pkg::REQ_REMOVE: begin
        icond = re <= s_r;
        jcond = rs < e_r;
      end
      default: begin
        jcond = rs <= s_r;
      end
    endcase
  end

  // Splice plan from the scan results.
  always_comb begin
    hit   = ci_r < cj_r;
    lt_s  = sti_r < s_r;
    gt_e  = ej1_r > e_r;
    c_jj  = cj_r;
    c_n   = 2'd0;
    c_ns0 = s_r;
    c_ne0 = e_r;
    if (req_r == isar_pkg::REQ_ADD) begin
      c_n   = 2'd1;
      c_ns0 = (hit && lt_s) ? sti_r : s_r;
      c_ne0 = (hit && gt_e) ? ej1_r : e_r;
      if (!hit) begin
        c_jj = ci_r;
      end
    end else if (!hit) begin
      c_jj = ci_r;
    end else begin
      c_n   = {1'b0, lt_s} + {1'b0, gt_e};
      c_ns0 = lt_s ? sti_r : e_r;
      c_ne0 = lt_s ? s_r : ej1_r;
    end
    c_base  = {1'b0, ci_r} + {{(CW-1){1'b0}}, c_n};
    c_total = {1'b0, count_r} - ({1'b0, c_jj} - {1'b0, ci_r})
              + {{(CW-1){1'b0}}, c_n};
    c_down  = c_base > {1'b0, c_jj};
    c_dist  = c_down ? (c_base - {1'b0, c_jj}) : ({1'b0, c_jj} - c_base);
  end

  // Memory port selection.
  always_comb begin
    rd_addr = ptr_r[AW-1:0];
    we      = 1'b0;
    wr_addr = mv_dst_r[AW-1:0];
    wr_data = rd_data;
    if (cmd == isar_pkg::CMD_SHIFT) begin
      rd_addr = src_r[AW-1:0];
      we      = mv_v_r;
    end else if (cmd == isar_pkg::CMD_FILL) begin
      we      = fk_r < n_r;
      wr_addr = AW'(lo_r + CW'(fk_r));
      wr_data = (fk_r == 2'd0) ? {ns0_r, ne0_r} : {ns1_r, ne1_r};
    end
  end

  assign cnt_ext = {7'd0, count_r};
  assign tot_ext = {7'd0, total_r};

  // Status toward the controller.
  always_comb begin
    stat.bad        = (req_r == isar_pkg::REQ_BAD) || (s_r >= e_r);
    stat.scan_done  = (ptr_r == count_r) && !rd_v_r;
    stat.skip       = full_r || (req_r == isar_pkg::REQ_QUERY);
    stat.shift_done = (rem_r == '0) && !mv_v_r;
    stat.fill_done  = fk_r == n_r;
  end

  // Stored count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd == isar_pkg::CMD_FINISH && !stat.bad && !stat.skip) begin
      count_r <= total_r[CW-1:0];
    end
  end

  // Request, scan, plan and move registers.
  always_ff @(posedge clk) begin
    unique case (cmd)
      isar_pkg::CMD_LOAD: begin
        req_r   <= in_req_type;
        s_r     <= in_span_start;
        e_r     <= in_span_end;
        ptr_r   <= '0;
        rd_v_r  <= 1'b0;
        ci_r    <= '0;
        cj_r    <= '0;
        got_i_r <= 1'b0;
        full_r  <= 1'b0;
        rem_r   <= '0;
        mv_v_r  <= 1'b0;
        fk_r    <= 2'd0;
        n_r     <= 2'd0;
      end
      isar_pkg::CMD_SCAN: begin
        rd_v_r <= ptr_r != count_r;
        if (ptr_r != count_r) begin
          ptr_r <= ptr_r + 1'b1;
        end
        if (rd_v_r) begin
          if (icond) begin
            ci_r <= ci_r + 1'b1;
          end else if (!got_i_r) begin
            sti_r   <= rs;
            got_i_r <= 1'b1;
          end
          if (jcond) begin
            cj_r  <= cj_r + 1'b1;
            ej1_r <= re;
          end
        end
      end
      isar_pkg::CMD_CALC: begin
        lo_r    <= ci_r;
        n_r     <= c_n;
        ns0_r   <= c_ns0;
        ne0_r   <= c_ne0;
        ns1_r   <= e_r;
        ne1_r   <= ej1_r;
        total_r <= c_total;
        full_r  <= c_total > (CW+1)'(CAPACITY);
        down_r  <= c_down;
        dist_r  <= c_dist[CW-1:0];
        rem_r   <= (c_dist == '0) ? '0 : (count_r - c_jj);
        src_r   <= c_down ? (count_r - 1'b1) : c_jj;
        fk_r    <= 2'd0;
      end
      isar_pkg::CMD_SHIFT: begin
        mv_v_r <= rem_r != '0;
        if (rem_r != '0) begin
          mv_dst_r <= down_r ? (src_r + dist_r) : (src_r - dist_r);
          src_r    <= down_r ? (src_r - 1'b1) : (src_r + 1'b1);
          rem_r    <= rem_r - 1'b1;
        end
      end
      isar_pkg::CMD_FILL: begin
        if (fk_r < n_r) begin
          fk_r <= fk_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd == isar_pkg::CMD_FINISH) begin
      out_covered        <= 1'b0;
      out_status         <= isar_pkg::ST_OK;
      out_interval_count <= cnt_ext[6:0];
      if (stat.bad) begin
        out_status <= isar_pkg::ST_INVALID;
      end else if (req_r == isar_pkg::REQ_QUERY) begin
        out_covered <= (cj_r != '0) && (ej1_r >= e_r);
      end else if (full_r) begin
        out_status <= isar_pkg::ST_FULL;
      end else begin
        out_interval_count <= tot_ext[6:0];
      end
    end
  end

endmodule

// ===== rtl/isar_ctrl.sv =====
// ----------------------------------------------------------------------------
// isar_ctrl
// Controller of the interval set: sequences the scan, plan, shift, fill
// and result phases of one transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isar_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output isar_pkg::cmd_t      cmd,
  input  isar_pkg::dp_stat_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_SHIFT,
    S_FILL,
    S_FINISH,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    cmd       = isar_pkg::CMD_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = isar_pkg::CMD_LOAD;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd = isar_pkg::CMD_SCAN;
        if (stat.bad) begin
          state_nxt = S_FINISH;
        end else if (stat.scan_done) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd       = isar_pkg::CMD_CALC;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.skip) begin
          state_nxt = S_FINISH;
        end else begin
          cmd = isar_pkg::CMD_SHIFT;
          if (stat.shift_done) begin
            state_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        cmd = isar_pkg::CMD_FILL;
        if (stat.fill_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd       = isar_pkg::CMD_FINISH;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_RESP;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/interval_set_add_remove_query.sv =====
// Sequence: a request is loaded and the table is scanned linearly, then the splice
// is planned; a query or a full update goes on to the result, an invalid request goes
// from the scan to the result, and a table update first shifts the moved entries and writes the new ones.
// Transactions: one at a time; the next is accepted only after the result has been
// taken; the linear scan and the one-entry-per-cycle tail shift bound the rate.
// Reset: synchronous, active low; it empties the table (count zero).
// ----------------------------------------------------------------------------
// interval_set_add_remove_query
// Sorted table of disjoint half-open intervals with add, remove and
// coverage query requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_set_add_remove_query #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_span_start,
  input  logic signed [31:0] in_span_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_covered,
  output logic [1:0]         out_status,
  output logic [6:0]         out_interval_count
);

  isar_pkg::cmd_t     cmd;
  isar_pkg::dp_stat_t stat;

  // Controller.
  isar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath.
  isar_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_req_type        (in_req_type),
    .in_span_start      (in_span_start),
    .in_span_end        (in_span_end),
    .out_covered        (out_covered),
    .out_status         (out_status),
    .out_interval_count (out_interval_count)
  );

endmodule
